// ===== src/running_median_two_heaps_top_assert.svh =====
// Assertion macros for the running median block.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef RUNNING_MEDIAN_TWO_HEAPS_TOP_ASSERT_SVH
`define RUNNING_MEDIAN_TWO_HEAPS_TOP_ASSERT_SVH

// Same-cycle implication
`define RMTH_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rmth: assertion failed");

// Next-cycle implication
`define RMTH_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rmth: assertion failed");

`endif

// ===== src/rmth_pkg.sv =====
// ----------------------------------------------------------------------------
// rmth_pkg
// Shared constants, datapath commands and status for the running median block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rmth_pkg;

  localparam int CAPACITY = 1024;
  localparam int SMP_W    = 32;
  localparam int MED_W    = 33;
  localparam int CNT_W    = 11;
  // heap index / size width: one heap holds up to CAPACITY/2 + 1 entries
  localparam int IDX_W    = $clog2(CAPACITY / 2 + 3);
  localparam int TOT_W    = IDX_W + 1;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,       // take a sample, pick the target heap
    OP_PUSH_INIT,  // open a hole at the end of the selected heap
    OP_UP_READ,    // read the parent of the hole
    OP_UP_MOVE,    // move parent down into the hole
    OP_WRITE_VAL,  // drop the carried value into the hole
    OP_BAL,        // pick the heap to pop for rebalancing
    OP_POP_INIT,   // shrink heap, read last entry
    OP_POP_TOP,    // carry last entry, read top
    OP_POP_SAVE,   // keep popped top, hole at root
    OP_DN_READ_L,  // read left child
    OP_DN_L,       // compare left child, read right child
    OP_DN_MOVE,    // move best child up into the hole
    OP_XFER,       // push popped value into the other heap
    OP_RD_TOPS,    // read lower top, then upper top
    OP_FIN         // load the output register
  } rmth_op_e;

  typedef struct packed {
    rmth_op_e op;
    logic     rd_upper; // for OP_RD_TOPS: second read of the pair
    logic     lat_upper; // latch upper top from read data
  } rmth_cmd_t;

  typedef struct packed {
    logic full;
    logic idx_zero;
    logic up_move;
    logic has_l;
    logic dn_move;
    logic need_bal;
  } rmth_stat_t;

endpackage

// ===== src/rmth_dp.sv =====
// ----------------------------------------------------------------------------
// rmth_dp
// Heap storage (one single-port memory holding both heaps) and the registers
// for sifting, the heap sizes, the tops and the output result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rmth_dp import rmth_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  rmth_cmd_t               cmd_i,
  output rmth_stat_t              stat_o,
  input  logic signed [SMP_W-1:0] sample_i,
  output logic signed [MED_W-1:0] median_doubled_o,
  output logic        [CNT_W-1:0] sample_count_o,
  output logic                    rejected_o
);

  localparam int MEM_DEPTH = 2 ** (IDX_W + 1);

  logic signed [SMP_W-1:0] mem [MEM_DEPTH];
  logic signed [SMP_W-1:0] rdata_q;

  logic [IDX_W-1:0] lsize_q, usize_q;
  logic [IDX_W-1:0] idx_q, cnt_q;
  logic             sel_q;   // 1: lower (max) heap, 0: upper (min) heap
  logic             rej_q;
  logic             best_l_q;
  logic signed [SMP_W-1:0] val_q, popv_q, bestv_q, ltop_q, utop_q;
  logic signed [MED_W-1:0] med_q;
  logic        [CNT_W-1:0] cnt_out_q;
  logic                    rej_out_q;

  logic [TOT_W-1:0] total;
  logic [IDX_W-1:0] size_sel, parent, size_m1;
  logic [IDX_W:0]   lft, rgt;
  logic             has_r, r_win, lt_above, up_above;
  logic             we, re;
  logic [IDX_W:0]   addr;
  logic signed [SMP_W-1:0] wdata;

  // heap order: a belongs above b
  function automatic logic above(input logic signed [SMP_W-1:0] a,
                                 input logic signed [SMP_W-1:0] b,
                                 input logic is_max);
    above = is_max ? (a > b) : (a < b);
  endfunction

  assign total    = TOT_W'(lsize_q) + TOT_W'(usize_q);
  assign size_sel = sel_q ? lsize_q : usize_q;
  assign size_m1  = size_sel - 1'b1;
  assign parent   = (idx_q - 1'b1) >> 1;
  assign lft      = {idx_q, 1'b1};
  assign rgt      = lft + 1'b1;
  assign has_r    = rgt < {1'b0, cnt_q};
  assign lt_above = above(rdata_q, val_q, sel_q);
  assign up_above = above(val_q, rdata_q, sel_q);
  assign r_win    = has_r && above(rdata_q, bestv_q, sel_q);

  // status toward the controller
  always_comb begin
    stat_o.full     = total >= TOT_W'(CAPACITY);
    stat_o.idx_zero = idx_q == '0;
    stat_o.up_move  = up_above;
    stat_o.has_l    = lft < {1'b0, cnt_q};
    stat_o.dn_move  = r_win || best_l_q;
    stat_o.need_bal = (lsize_q == usize_q + 2'd2) || (usize_q > lsize_q);
  end

  // memory port control
  always_comb begin
    we    = 1'b0;
    re    = 1'b0;
    addr  = {sel_q, idx_q};
    wdata = val_q;
    case (cmd_i.op)
      OP_UP_READ: begin
        re   = 1'b1;
        addr = {sel_q, parent};
      end
      OP_UP_MOVE: begin
        we    = 1'b1;
        wdata = rdata_q;
      end
      OP_WRITE_VAL: we = 1'b1;
      OP_POP_INIT: begin
        re   = 1'b1;
        addr = {sel_q, size_m1};
      end
      OP_POP_TOP: begin
        re   = 1'b1;
        addr = {sel_q, {IDX_W{1'b0}}};
      end
      OP_DN_READ_L: begin
        re   = 1'b1;
        addr = {sel_q, lft[IDX_W-1:0]};
      end
      OP_DN_L: begin
        re   = 1'b1;
        addr = {sel_q, rgt[IDX_W-1:0]};
      end
      OP_DN_MOVE: begin
        we    = 1'b1;
        wdata = r_win ? rdata_q : bestv_q;
      end
      OP_RD_TOPS: begin
        re   = 1'b1;
        addr = {~cmd_i.rd_upper, {IDX_W{1'b0}}};
      end
      default: ;
    endcase
  end

  // heap memory
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[addr];
    end
  end

  // heap sizes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lsize_q <= '0;
      usize_q <= '0;
    end else begin
      case (cmd_i.op)
        OP_PUSH_INIT: begin
          if (sel_q) lsize_q <= lsize_q + 1'b1;
          else       usize_q <= usize_q + 1'b1;
        end
        OP_POP_INIT: begin
          if (sel_q) lsize_q <= size_m1;
          else       usize_q <= size_m1;
        end
        default: ;
      endcase
    end
  end

  // sift registers and tops
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        val_q <= sample_i;
        sel_q <= (lsize_q == '0) || (sample_i < ltop_q);
        rej_q <= stat_o.full;
      end
      OP_PUSH_INIT: idx_q <= size_sel;
      OP_UP_MOVE:   idx_q <= parent;
      OP_BAL:       sel_q <= lsize_q == usize_q + 2'd2;
      OP_POP_INIT:  cnt_q <= size_m1;
      OP_POP_TOP:   val_q <= rdata_q;
      OP_POP_SAVE: begin
        popv_q <= rdata_q;
        idx_q  <= '0;
      end
      OP_DN_L: begin
        best_l_q <= lt_above;
        bestv_q  <= lt_above ? rdata_q : val_q;
      end
      OP_DN_MOVE: idx_q <= r_win ? rgt[IDX_W-1:0] : lft[IDX_W-1:0];
      OP_XFER: begin
        val_q <= popv_q;
        sel_q <= ~sel_q;
      end
      OP_RD_TOPS: begin
        if (cmd_i.rd_upper) ltop_q <= rdata_q;
      end
      default: ;
    endcase
    if (cmd_i.lat_upper) begin
      utop_q <= rdata_q;
    end
  end

  // output result
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_FIN) begin
      if (total[0]) begin
        med_q <= {ltop_q, 1'b0};
      end else begin
        med_q <= MED_W'(ltop_q) + MED_W'(utop_q);
      end
      cnt_out_q <= CNT_W'(total);
      rej_out_q <= rej_q;
    end
  end

  assign median_doubled_o = med_q;
  assign sample_count_o   = cnt_out_q;
  assign rejected_o       = rej_out_q;

endmodule

// ===== src/rmth_ctrl.sv =====
// ----------------------------------------------------------------------------
// rmth_ctrl
// Sequencer for insert, rebalance and top readout; owns both handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rmth_ctrl import rmth_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  rmth_stat_t stat_i,
  output rmth_cmd_t  cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_CHK, ST_PUSH, ST_UP, ST_UP_STEP, ST_BAL, ST_POP, ST_POP_TOP,
    ST_POP_SAVE, ST_DN, ST_DN_L, ST_DN_R, ST_XFER, ST_RD_L, ST_RD_U, ST_LAT_U,
    ST_FIN
  } state_e;

  state_e state_q, state_d;
  logic   second_q, second_d;   // set while doing the rebalancing pop and push
  logic   out_valid_q, out_valid_d;
  logic   rd_l;

  state_e after_push;
  assign after_push = second_q ? ST_RD_L : ST_BAL;

  always_comb begin
    state_d     = state_q;
    second_d    = second_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '{op: OP_NONE, rd_upper: 1'b0, lat_upper: 1'b0};
    rd_l        = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          second_d = 1'b0;
          state_d  = ST_CHK;
        end
      end
      ST_CHK: state_d = stat_i.full ? ST_FIN : ST_PUSH;
      ST_PUSH: begin
        cmd_o.op = OP_PUSH_INIT;
        state_d  = ST_UP;
      end
      // sift up
      ST_UP: begin
        if (stat_i.idx_zero) begin
          cmd_o.op = OP_WRITE_VAL;
          state_d  = after_push;
          rd_l     = second_q;
        end else begin
          cmd_o.op = OP_UP_READ;
          state_d  = ST_UP_STEP;
        end
      end
      ST_UP_STEP: begin
        if (stat_i.up_move) begin
          cmd_o.op = OP_UP_MOVE;
          state_d  = ST_UP;
        end else begin
          cmd_o.op = OP_WRITE_VAL;
          state_d  = after_push;
          rd_l     = second_q;
        end
      end
      ST_BAL: begin
        if (stat_i.need_bal) begin
          cmd_o.op = OP_BAL;
          second_d = 1'b1;
          state_d  = ST_POP;
        end else begin
          rd_l    = 1'b1;
          state_d = ST_RD_L;
        end
      end
      // pop
      ST_POP: begin
        cmd_o.op = OP_POP_INIT;
        state_d  = ST_POP_TOP;
      end
      ST_POP_TOP: begin
        cmd_o.op = OP_POP_TOP;
        state_d  = ST_POP_SAVE;
      end
      ST_POP_SAVE: begin
        cmd_o.op = OP_POP_SAVE;
        state_d  = ST_DN;
      end
      // sift down
      ST_DN: begin
        if (stat_i.has_l) begin
          cmd_o.op = OP_DN_READ_L;
          state_d  = ST_DN_L;
        end else begin
          cmd_o.op = OP_WRITE_VAL;
          state_d  = ST_XFER;
        end
      end
      ST_DN_L: begin
        cmd_o.op = OP_DN_L;
        state_d  = ST_DN_R;
      end
      ST_DN_R: begin
        if (stat_i.dn_move) begin
          cmd_o.op = OP_DN_MOVE;
          state_d  = ST_DN;
        end else begin
          cmd_o.op = OP_WRITE_VAL;
          state_d  = ST_XFER;
        end
      end
      ST_XFER: begin
        cmd_o.op = OP_XFER;
        state_d  = ST_PUSH;
      end
      // top readout: lower top first, then upper top
      ST_RD_L: begin
        cmd_o.op       = OP_RD_TOPS;
        cmd_o.rd_upper = 1'b0;
        state_d        = ST_RD_U;
      end
      ST_RD_U: begin
        cmd_o.op       = OP_RD_TOPS;
        cmd_o.rd_upper = 1'b1;
        state_d        = ST_LAT_U;
      end
      ST_LAT_U: begin
        cmd_o.lat_upper = 1'b1;
        state_d         = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op    = OP_FIN;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    // the last write of an insert holds the memory port, so the lower top
    // read is issued from ST_RD_L after it
    if (rd_l) begin
      state_d = ST_RD_L;
    end
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      second_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      second_q    <= second_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = state_q == ST_IDLE;
  assign out_valid_o = out_valid_q;

endmodule

// ===== src/running_median_two_heaps_top.sv =====
// ----------------------------------------------------------------------------
// running_median_two_heaps_top
// Running median over a stream of signed samples using a max-heap for the
// lower half and a min-heap for the upper half.
// ----------------------------------------------------------------------------
//  channel | signals                                          | direction
//  --------+--------------------------------------------------+----------
//  in      | in_valid_i, in_ready_o, sample_i                 | to block
//  out     | out_valid_o, out_ready_i, median_doubled_o,      | from block
//          | sample_count_o, rejected_o                       |
//
//  One item at a time, paced by the single-port heap memory (one read or
//  write per cycle): each level of sift up reads the parent and moves it,
//  each level of sift down reads both children and moves the best one.
//  A rejected sample skips both heaps. Reset empties both heaps at once.
//  A new sample is taken while the previous result still waits on out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module running_median_two_heaps_top import rmth_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic signed [SMP_W-1:0] sample_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [MED_W-1:0] median_doubled_o,
  output logic        [CNT_W-1:0] sample_count_o,
  output logic                    rejected_o
);

  rmth_cmd_t  cmd;
  rmth_stat_t stat;

  rmth_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  rmth_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .sample_i         (sample_i),
    .median_doubled_o (median_doubled_o),
    .sample_count_o   (sample_count_o),
    .rejected_o       (rejected_o)
  );

endmodule

// ===== src/rmth_checker.sv =====
// ----------------------------------------------------------------------------
// rmth_checker
// Port-level checks on the running median block, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "running_median_two_heaps_top_assert.svh"

module rmth_checker import rmth_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_o,
  input logic                    out_valid_o,
  input logic                    out_ready_i,
  input logic signed [MED_W-1:0] median_doubled_o,
  input logic        [CNT_W-1:0] sample_count_o,
  input logic                    rejected_o
);

  // a stalled result holds
  `RMTH_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(median_doubled_o) && $stable(sample_count_o))
  // a drop only happens with a full store
  `RMTH_ASSERT_IMP(a_rej_full, out_valid_o && rejected_o, sample_count_o == CNT_W'(CAPACITY))
  // odd count: median is twice a sample, so no half
  `RMTH_ASSERT_IMP(a_odd_whole, out_valid_o && sample_count_o[0], !median_doubled_o[0])
  // one sample in flight at a time
  `RMTH_ASSERT_NXT(a_busy, in_valid_i && in_ready_o, !in_ready_o)

endmodule

bind running_median_two_heaps_top rmth_checker u_rmth_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_o       (in_ready_o),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .median_doubled_o (median_doubled_o),
  .sample_count_o   (sample_count_o),
  .rejected_o       (rejected_o)
);
